// ----- rtl/core/pedal_hold_speed_integrator_core_macros.svh -----
// Assertion macros for the pedal hold and speed integrator core.
// All three forms sample on the rising clock edge and are off while reset is high.
`ifndef PEDAL_HOLD_SPEED_INTEGRATOR_CORE_MACROS_SVH
`define PEDAL_HOLD_SPEED_INTEGRATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define PHSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PHSI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PHSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PHSI_ASSERT(label, clk, rst, prop, msg)

`define PHSI_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define PHSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/phsi_pkg.sv -----
`default_nettype none

package phsi_pkg;

   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 16;
   localparam int HOLD_W   = 16;
   localparam int SPEED_W  = 24;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   // Speed plus one product minus another fits with two bits of headroom.
   localparam int SUM_W    = PROD_W + 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_ENABLE    = 3'd0,
      CSR_PRESS_THRESHOLD = 3'd1,
      CSR_HOLD_TICKS      = 3'd2,
      CSR_ACCEL_GAIN      = 3'd3,
      CSR_BRAKE_GAIN      = 3'd4,
      CSR_SPEED_CEILING   = 3'd5
   } csr_index_type;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd50;
   localparam logic [HOLD_W-1:0]   HOLD_RESET      = 16'd10;

   typedef struct packed {
      logic                input_enable;
      logic [SAMPLE_W-1:0] press_threshold;
      logic [HOLD_W-1:0]   hold_ticks;
      logic [GAIN_W-1:0]   accel_gain;
      logic [GAIN_W-1:0]   brake_gain;
      logic [SPEED_W-1:0]  speed_ceiling;
   } cfg_type;

   typedef struct packed {
      logic              accel_press;
      logic              brake_press;
      logic [PROD_W-1:0] speed_up;
      logic [PROD_W-1:0] speed_down;
   } stage_type;

   typedef struct packed {
      logic [HOLD_W-1:0] count;
      logic              flag;
   } hold_type;

   // One tick of a pedal hold counter: a press reloads, then a nonzero count
   // steps down and the flag drops when it reaches zero.
   function automatic hold_type hold_step(logic press, hold_type cur,
                                          logic [HOLD_W-1:0] reload);
      hold_type          nxt;
      logic [HOLD_W-1:0] start;
      start     = press ? reload : cur.count;
      nxt.flag  = press | cur.flag;
      nxt.count = start;
      if (start != '0) begin
         nxt.count = start - {{(HOLD_W-1){1'b0}}, 1'b1};
         if (nxt.count == '0) begin
            nxt.flag = 1'b0;
         end
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pedal_hold_speed_integrator_core.sv -----
// Throughput: one beat per cycle unless the output stalls; a beat moves from the stage
// register to the result register when that is free. The compare and gain multiplies sit
// before the stage register, hold counters, speed add and clamp before the result register.
// Reset (synchronous, active high) clears speed, hold counters, flags and valids,
// and loads the register defaults; the block is ready in the cycle after reset.
`default_nettype none

module pedal_hold_speed_integrator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [phsi_pkg::SAMPLE_W-1:0]        req_accel_sample,
   input  wire logic [phsi_pkg::SAMPLE_W-1:0]        req_brake_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [phsi_pkg::SPEED_W-1:0]              rsp_speed_now,
   output logic                                      rsp_accel_held,
   output logic                                      rsp_brake_held,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [phsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [phsi_pkg::SPEED_W-1:0]         csr_data
);

   phsi_pkg::cfg_type   cfg_ff;
   phsi_pkg::cfg_type   cfg_in;
   phsi_pkg::stage_type stage;
   logic                step;
   logic                out_free;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            phsi_pkg::CSR_INPUT_ENABLE:
               cfg_in.input_enable = csr_data[0];
            phsi_pkg::CSR_PRESS_THRESHOLD:
               cfg_in.press_threshold = csr_data[phsi_pkg::SAMPLE_W-1:0];
            phsi_pkg::CSR_HOLD_TICKS:
               cfg_in.hold_ticks = csr_data[phsi_pkg::HOLD_W-1:0];
            phsi_pkg::CSR_ACCEL_GAIN:
               cfg_in.accel_gain = csr_data[phsi_pkg::GAIN_W-1:0];
            phsi_pkg::CSR_BRAKE_GAIN:
               cfg_in.brake_gain = csr_data[phsi_pkg::GAIN_W-1:0];
            phsi_pkg::CSR_SPEED_CEILING:
               cfg_in.speed_ceiling = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_enable    <= 1'b0;
         cfg_ff.press_threshold <= phsi_pkg::THRESHOLD_RESET;
         cfg_ff.hold_ticks      <= phsi_pkg::HOLD_RESET;
         cfg_ff.accel_gain      <= '0;
         cfg_ff.brake_gain      <= '0;
         cfg_ff.speed_ceiling   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The result register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid || !rsp_stall;

   phsi_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_accel_sample (req_accel_sample),
      .req_brake_sample (req_brake_sample),
      .cfg              (cfg_ff),
      .out_free         (out_free),
      .step             (step),
      .stage            (stage)
   );

   phsi_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stage      (stage),
      .cfg        (cfg_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .speed_now  (rsp_speed_now),
      .accel_held (rsp_accel_held),
      .brake_held (rsp_brake_held)
   );

endmodule

`default_nettype wire

// ----- rtl/core/phsi_front.sv -----
`default_nettype none

module phsi_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [phsi_pkg::SAMPLE_W-1:0]     req_accel_sample,
   input  wire logic [phsi_pkg::SAMPLE_W-1:0]     req_brake_sample,
   input  wire phsi_pkg::cfg_type                 cfg,
   input  wire logic                              out_free,
   output logic                                   step,
   output phsi_pkg::stage_type                    stage
);

   logic                stage_valid_ff;
   logic                stage_valid_in;
   phsi_pkg::stage_type stage_ff;
   phsi_pkg::stage_type stage_in;
   logic                accept;
   logic                accel_press;
   logic                brake_press;

   assign req_stall = stage_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign step      = stage_valid_ff && out_free;
   assign stage     = stage_ff;

   assign accel_press = req_accel_sample > cfg.press_threshold;
   assign brake_press = req_brake_sample > cfg.press_threshold;

   always_comb begin
      stage_in.accel_press = accel_press;
      stage_in.brake_press = brake_press;
      stage_in.speed_up    = '0;
      stage_in.speed_down  = '0;
      if (cfg.input_enable && accel_press) begin
         stage_in.speed_up = req_accel_sample * cfg.accel_gain;
      end
      if (cfg.input_enable && brake_press) begin
         stage_in.speed_down = req_brake_sample * cfg.brake_gain;
      end
   end

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (step) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/phsi_accum.sv -----
`default_nettype none

`include "pedal_hold_speed_integrator_core_macros.svh"

module phsi_accum (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire phsi_pkg::stage_type             stage,
   input  wire phsi_pkg::cfg_type               cfg,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic [phsi_pkg::SPEED_W-1:0]         speed_now,
   output logic                                 accel_held,
   output logic                                 brake_held
);

   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [phsi_pkg::SPEED_W-1:0]        speed_ff;
   logic [phsi_pkg::SPEED_W-1:0]        speed_in;
   phsi_pkg::hold_type                  accel_ff;
   phsi_pkg::hold_type                  accel_in;
   phsi_pkg::hold_type                  brake_ff;
   phsi_pkg::hold_type                  brake_in;
   logic signed [phsi_pkg::SUM_W-1:0]   sum;
   logic signed [phsi_pkg::SUM_W-1:0]   limit;
   logic                                speed_in_range;

   assign accel_in = phsi_pkg::hold_step(stage.accel_press, accel_ff, cfg.hold_ticks);
   assign brake_in = phsi_pkg::hold_step(stage.brake_press, brake_ff, cfg.hold_ticks);

   assign sum = $signed({{(phsi_pkg::SUM_W-phsi_pkg::SPEED_W){1'b0}}, speed_ff})
              + $signed({2'b00, stage.speed_up})
              - $signed({2'b00, stage.speed_down});
   assign limit = $signed({{(phsi_pkg::SUM_W-phsi_pkg::SPEED_W){1'b0}}, cfg.speed_ceiling});

   always_comb begin
      if (sum > limit) begin
         speed_in = cfg.speed_ceiling;
      end else if (sum < 0) begin
         speed_in = '0;
      end else begin
         speed_in = sum[phsi_pkg::SPEED_W-1:0];
      end
   end

   // The result register is the integrator state; it only moves on a step,
   // which never happens while a finished beat is stalled.
   always_comb begin
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         speed_ff     <= '0;
         accel_ff     <= '0;
         brake_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step) begin
            speed_ff <= speed_in;
            accel_ff <= accel_in;
            brake_ff <= brake_in;
         end
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign speed_now  = speed_ff;
   assign accel_held = accel_ff.flag;
   assign brake_held = brake_ff.flag;

   assign speed_in_range = speed_ff <= cfg.speed_ceiling;

   `PHSI_ASSERT_IMPL(a_speed_clamped, clock, reset, out_valid_ff, speed_in_range, "over ceiling")
   `PHSI_ASSERT(a_accel_hold, clock, reset, accel_ff.flag || ~|accel_ff.count, "accel flag low")
   `PHSI_ASSERT(a_brake_hold, clock, reset, brake_ff.flag || ~|brake_ff.count, "brake flag low")
   `PHSI_ASSERT_NEXT(a_no_step, clock, reset, !step, $stable({speed_ff, accel_ff}), "state moved")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [phsi_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [phsi_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int STUCK_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 10;
   localparam int TICKS_PER_PHASE = 40;

   typedef struct packed {
      logic [phsi_pkg::SAMPLE_W-1:0] accel;
      logic [phsi_pkg::SAMPLE_W-1:0] brake;
   } pedal_tick_type;

   typedef struct packed {
      logic [phsi_pkg::SPEED_W-1:0] speed;
      logic                         accel_held;
      logic                         brake_held;
   } pedal_status_type;

   typedef struct packed {
      logic [phsi_pkg::HOLD_W-1:0] count;
      logic                        held;
   } hold_state_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [phsi_pkg::SAMPLE_W-1:0]  req_accel_sample = '0;
   logic [phsi_pkg::SAMPLE_W-1:0]  req_brake_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [phsi_pkg::SPEED_W-1:0]   rsp_speed_now;
   logic                           rsp_accel_held;
   logic                           rsp_brake_held;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [phsi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [phsi_pkg::SPEED_W-1:0]   csr_data = '0;

   pedal_tick_type   tick_queue[$];
   pedal_status_type predicted_status[$];
   pedal_tick_type   next_tick;
   pedal_status_type want;
   bit               idle_sender = 1'b0;
   bit               stall_receiver = 1'b0;
   int               ticks_in_flight = 0;
   int unsigned      failures = 0;
   int unsigned      gap_left = 0;
   int unsigned      stall_left = 0;
   int unsigned      stuck_cycles = 0;

   // Shadow of the block: register file, speed and both hold counters.
   phsi_pkg::cfg_type            pedal_cfg;
   logic [phsi_pkg::SPEED_W-1:0] speed_model;
   hold_state_type               accel_hold;
   hold_state_type               brake_hold;

   pedal_hold_speed_integrator_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_accel_sample(req_accel_sample),
      .req_brake_sample(req_brake_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_speed_now(rsp_speed_now),
      .rsp_accel_held(rsp_accel_held),
      .rsp_brake_held(rsp_brake_held),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic hold_state_type next_hold(input logic press,
                                                input hold_state_type cur);
      hold_state_type nxt;
      nxt = cur;
      if (press) begin
         nxt.held  = 1'b1;
         nxt.count = pedal_cfg.hold_ticks;
      end
      // With a zero reload the flag stays up, since nothing is left to count down.
      if (nxt.count != '0) begin
         nxt.count = nxt.count - 1'b1;
         if (nxt.count == '0) begin
            nxt.held = 1'b0;
         end
      end
      return nxt;
   endfunction

   function automatic void integrate_tick(input logic [phsi_pkg::SAMPLE_W-1:0] accel,
                                          input logic [phsi_pkg::SAMPLE_W-1:0] brake);
      logic             accel_press;
      logic             brake_press;
      longint           delta;
      longint           sum;
      pedal_status_type status;
      accel_press = accel > pedal_cfg.press_threshold;
      brake_press = brake > pedal_cfg.press_threshold;
      delta = 0;
      // Only a press in this tick moves the speed; a pedal that is merely held does not.
      if (pedal_cfg.input_enable) begin
         if (accel_press) begin
            delta += longint'(accel) * longint'(pedal_cfg.accel_gain);
         end
         if (brake_press) begin
            delta -= longint'(brake) * longint'(pedal_cfg.brake_gain);
         end
      end
      accel_hold = next_hold(accel_press, accel_hold);
      brake_hold = next_hold(brake_press, brake_hold);
      sum = longint'(speed_model) + delta;
      if (sum > longint'(pedal_cfg.speed_ceiling)) begin
         sum = longint'(pedal_cfg.speed_ceiling);
      end else if (sum < 0) begin
         sum = 0;
      end
      speed_model       = sum[phsi_pkg::SPEED_W-1:0];
      status.speed      = speed_model;
      status.accel_held = accel_hold.held;
      status.brake_held = brake_hold.held;
      predicted_status.push_back(status);
   endfunction

   function automatic void apply_csr(input logic [phsi_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [phsi_pkg::SPEED_W-1:0] data);
      case (idx)
         phsi_pkg::CSR_INPUT_ENABLE:
            pedal_cfg.input_enable = data[0];
         phsi_pkg::CSR_PRESS_THRESHOLD:
            pedal_cfg.press_threshold = data[phsi_pkg::SAMPLE_W-1:0];
         phsi_pkg::CSR_HOLD_TICKS:
            pedal_cfg.hold_ticks = data[phsi_pkg::HOLD_W-1:0];
         phsi_pkg::CSR_ACCEL_GAIN:
            pedal_cfg.accel_gain = data[phsi_pkg::GAIN_W-1:0];
         phsi_pkg::CSR_BRAKE_GAIN:
            pedal_cfg.brake_gain = data[phsi_pkg::GAIN_W-1:0];
         phsi_pkg::CSR_SPEED_CEILING:
            pedal_cfg.speed_ceiling = data;
         default: ;
      endcase
   endfunction

   function automatic void add_tick(input logic [phsi_pkg::SAMPLE_W-1:0] accel,
                                    input logic [phsi_pkg::SAMPLE_W-1:0] brake);
      pedal_tick_type t;
      t.accel = accel;
      t.brake = brake;
      tick_queue.push_back(t);
      ticks_in_flight++;
   endfunction

   function automatic logic [phsi_pkg::SAMPLE_W-1:0] pick_sample(
         input logic [phsi_pkg::SAMPLE_W-1:0] thr, input int unsigned press_pct);
      logic [phsi_pkg::SAMPLE_W-1:0] s;
      case ($urandom_range(0, 7))
         0: s = '0;
         1: s = '1;
         2: s = thr;
         3: s = (thr == '1) ? thr : thr + 1'b1;
         4: s = 12'($urandom_range(0, 4095));
         default: begin
            if (thr != '1 && $urandom_range(0, 99) < press_pct) begin
               s = 12'($urandom_range(int'(thr) + 1, 4095));
            end else begin
               s = 12'($urandom_range(0, int'(thr)));
            end
         end
      endcase
      return s;
   endfunction

   function automatic logic [phsi_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return 16'($urandom_range(0, 600));
      endcase
   endfunction

   // Driver; it also keeps the shadow model in step with every accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         gap_left     = 0;
         pedal_cfg    = '0;
         pedal_cfg.press_threshold = phsi_pkg::THRESHOLD_RESET;
         pedal_cfg.hold_ticks      = phsi_pkg::HOLD_RESET;
         speed_model  = '0;
         accel_hold   = '0;
         brake_hold   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            integrate_tick(req_accel_sample, req_brake_sample);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               next_tick = tick_queue.pop_front();
               req_accel_sample <= next_tick.accel;
               req_brake_sample <= next_tick.brake;
               req_valid        <= 1'b1;
               gap_left = idle_sender ? $urandom_range(0, 3) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         ticks_in_flight--;
         if (predicted_status.size() == 0) begin
            failures++;
            $display("%0t ns: result with no tick pending: expected none, got speed %0d %s",
                     $time, rsp_speed_now,
                     $sformatf("accel_held %0b brake_held %0b", rsp_accel_held, rsp_brake_held));
         end else begin
            want = predicted_status.pop_front();
            if (want.speed !== rsp_speed_now || want.accel_held !== rsp_accel_held ||
                want.brake_held !== rsp_brake_held) begin
               failures++;
               $display("%0t ns: mismatch: expected speed %0d accel_held %0b brake_held %0b, %s",
                        $time, want.speed, want.accel_held, want.brake_held,
                        $sformatf("got speed %0d accel_held %0b brake_held %0b",
                                  rsp_speed_now, rsp_accel_held, rsp_brake_held));
            end
         end
         stall_left = stall_receiver ? $urandom_range(0, 3) : 0;
         rsp_stall <= (stall_left != 0);
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [phsi_pkg::CSR_IDX_W-1:0] idx,
                            input logic [phsi_pkg::SPEED_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(input logic en, input logic [phsi_pkg::SAMPLE_W-1:0] thr,
                              input logic [phsi_pkg::HOLD_W-1:0] hold,
                              input logic [phsi_pkg::GAIN_W-1:0] up_gain,
                              input logic [phsi_pkg::GAIN_W-1:0] down_gain,
                              input logic [phsi_pkg::SPEED_W-1:0] top);
      // Bits above each register's width carry noise that the block must drop.
      write_csr(phsi_pkg::CSR_INPUT_ENABLE, {23'($urandom), en});
      write_csr(phsi_pkg::CSR_PRESS_THRESHOLD, {12'($urandom), thr});
      write_csr(phsi_pkg::CSR_HOLD_TICKS, {8'($urandom), hold});
      write_csr(phsi_pkg::CSR_ACCEL_GAIN, {8'($urandom), up_gain});
      write_csr(phsi_pkg::CSR_BRAKE_GAIN, {8'($urandom), down_gain});
      write_csr(phsi_pkg::CSR_SPEED_CEILING, top);
      write_csr(CSR_UNMAPPED_LO, 24'($urandom));
      write_csr(CSR_UNMAPPED_HI, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (ticks_in_flight > 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int unsigned                   phase;
      int unsigned                   n;
      int unsigned                   up_pct;
      int unsigned                   down_pct;
      logic [phsi_pkg::SAMPLE_W-1:0] thr;
      logic [phsi_pkg::HOLD_W-1:0]   hold;
      logic [phsi_pkg::SPEED_W-1:0]  top;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      idle_sender    = 1'b1;
      stall_receiver = 1'b1;

      // Register defaults: input disabled, so the speed stays at zero.
      add_tick(12'd0, 12'd0);
      add_tick(12'hFFF, 12'hFFF);
      add_tick(12'd51, 12'd0);
      add_tick(12'd0, 12'd51);
      wait_idle();

      // Press, hold without press, expiry, a sample right at the threshold,
      // both pedals at once and a brake that drives the speed below zero.
      load_config(1'b1, 12'd50, 16'd3, 16'd100, 16'd80, '1);
      add_tick(12'hFFF, 12'd0);
      add_tick(12'd50, 12'd0);
      add_tick(12'd0, 12'd0);
      add_tick(12'd0, 12'd0);
      add_tick(12'd51, 12'd50);
      add_tick(12'd0, 12'hFFF);
      add_tick(12'hFFF, 12'hFFF);
      add_tick(12'd0, 12'hFFF);
      add_tick(12'd0, 12'hFFF);
      wait_idle();

      // A zero reload leaves both flags up; full gains saturate at the top.
      load_config(1'b1, 12'd0, 16'd0, '1, '1, '1);
      add_tick(12'd1, 12'd0);
      add_tick(12'd0, 12'd0);
      add_tick(12'hFFF, 12'd1);
      add_tick(12'd0, 12'hFFF);
      add_tick(12'hFFF, 12'd0);
      wait_idle();

      // Nothing can be pressed, and the lowered ceiling pulls the speed down.
      load_config(1'b1, '1, '1, 16'd1, 16'd1, 24'd1000);
      add_tick(12'hFFF, 12'hFFF);
      add_tick(12'd0, 12'd0);
      wait_idle();

      // A ceiling of zero, and a reload of one that expires in the same tick.
      load_config(1'b1, 12'd100, 16'd1, 16'd500, 16'd0, '0);
      add_tick(12'hFFF, 12'hFFF);
      add_tick(12'hFFF, 12'd0);
      wait_idle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: thr = '0;
            1: thr = '1;
            default: thr = 12'($urandom_range(0, 3000));
         endcase
         case ($urandom_range(0, 4))
            0: hold = '0;
            1: hold = 16'd1;
            2: hold = '1;
            default: hold = 16'($urandom_range(1, 20));
         endcase
         case ($urandom_range(0, 3))
            0: top = '0;
            1: top = '1;
            default: top = 24'($urandom_range(1000, 24'hFFFFFF));
         endcase
         load_config($urandom_range(0, 4) != 0, thr, hold, pick_gain(), pick_gain(), top);
         // The first phase runs back to back with no gaps on either side.
         idle_sender    = (phase != 0) && ($urandom_range(0, 2) != 0);
         stall_receiver = (phase != 0) && ($urandom_range(0, 2) != 0);
         up_pct   = $urandom_range(20, 90);
         down_pct = $urandom_range(5, 60);
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            add_tick(pick_sample(thr, up_pct), pick_sample(thr, down_pct));
            // Midway through one phase the sender holds off until every beat is back.
            if (phase == RANDOM_PHASES / 2 && n == TICKS_PER_PHASE / 2) begin
               wait_idle();
            end
         end
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
